// ===== rtl/ptcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcd_pkg
// shared types and codes of the pdf417 text compaction decoder
// ----------------------------------------------------------------------------
package ptcd_pkg;

  localparam int CW_W    = 10;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TERM  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

  // text sub-modes
  localparam logic [MODE_W-1:0] MODE_ALPHA      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOWER      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIXED      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PUNCT      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ASHIFT     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PSHIFT     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PSHIFT_NEW = 3'd6;

  // special codewords
  localparam logic [CW_W-1:0] CW_TEXT_LATCH = 10'd900;
  localparam logic [CW_W-1:0] CW_BYTE_SHIFT = 10'd913;
  localparam logic [CW_W-1:0] CW_ECI_GEN    = 10'd926;

  typedef struct packed {
    logic [MODE_W-1:0] sub_mode;
    logic [1:0]        saved_mode;
    logic [1:0]        eci_args_left;
    logic              byte_pending;
    logic              error_seen;
  } dec_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CW_W-1:0]   value;
  } result_t;

  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    cnt;
  } bundle_t;

endpackage

// ===== rtl/ptcd_step.sv =====
// ----------------------------------------------------------------------------
// ptcd_step
// decode of one codeword: next decoder state and up to three results
// ----------------------------------------------------------------------------
module ptcd_step (
  input  ptcd_pkg::dec_state_t      st,
  input  logic [ptcd_pkg::CW_W-1:0] codeword,
  input  logic                      last_codeword,
  output ptcd_pkg::dec_state_t      st_nxt,
  output ptcd_pkg::bundle_t         bundle
);
  import ptcd_pkg::*;

  typedef struct packed {
    logic              has;
    logic [6:0]        ch;
    logic [MODE_W-1:0] mode;
    logic [1:0]        saved;
  } text_res_t;

  function automatic logic [6:0] punct_char(input logic [4:0] v);
    logic [6:0] c;
    case (v)
      5'd0:    c = 7'd59;
      5'd1:    c = 7'd60;
      5'd2:    c = 7'd62;
      5'd3:    c = 7'd64;
      5'd4:    c = 7'd91;
      5'd5:    c = 7'd92;
      5'd6:    c = 7'd93;
      5'd7:    c = 7'd95;
      5'd8:    c = 7'd96;
      5'd9:    c = 7'd126;
      5'd10:   c = 7'd33;
      5'd11:   c = 7'd13;
      5'd12:   c = 7'd9;
      5'd13:   c = 7'd44;
      5'd14:   c = 7'd58;
      5'd15:   c = 7'd10;
      5'd16:   c = 7'd45;
      5'd17:   c = 7'd46;
      5'd18:   c = 7'd36;
      5'd19:   c = 7'd47;
      5'd20:   c = 7'd34;
      5'd21:   c = 7'd124;
      5'd22:   c = 7'd42;
      5'd23:   c = 7'd40;
      5'd24:   c = 7'd41;
      5'd25:   c = 7'd63;
      5'd26:   c = 7'd123;
      5'd27:   c = 7'd125;
      5'd28:   c = 7'd39;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] mixed_char(input logic [4:0] v);
    logic [6:0] c;
    case (v)
      5'd10:   c = 7'd38;
      5'd11:   c = 7'd13;
      5'd12:   c = 7'd9;
      5'd13:   c = 7'd44;
      5'd14:   c = 7'd58;
      5'd15:   c = 7'd35;
      5'd16:   c = 7'd45;
      5'd17:   c = 7'd46;
      5'd18:   c = 7'd36;
      5'd19:   c = 7'd47;
      5'd20:   c = 7'd43;
      5'd21:   c = 7'd37;
      5'd22:   c = 7'd42;
      5'd23:   c = 7'd61;
      5'd24:   c = 7'd94;
      default: c = (v < 5'd10) ? 7'(7'd48 + 7'(v)) : 7'd0;
    endcase
    return c;
  endfunction

  function automatic text_res_t text_step(input logic [MODE_W-1:0] mode,
                                          input logic [1:0] saved,
                                          input logic [4:0] v);
    text_res_t r;
    logic [MODE_W-1:0] m;
    r.has   = 1'b0;
    r.ch    = 7'd0;
    r.mode  = mode;
    r.saved = saved;
    m = (mode == MODE_PSHIFT_NEW) ? MODE_PSHIFT : mode;
    case (m)
      MODE_ALPHA, MODE_LOWER: begin
        if (v < 5'd26) begin
          r.has = 1'b1;
          r.ch  = 7'((m == MODE_ALPHA) ? 7'd65 : 7'd97) + 7'(v);
        end else if (v == 5'd26) begin
          r.has = 1'b1;
          r.ch  = 7'd32;
        end else if (v == 5'd27 && m == MODE_ALPHA) begin
          r.mode = MODE_LOWER;
        end else if (v == 5'd27) begin
          r.saved = m[1:0];
          r.mode  = MODE_ASHIFT;
        end else if (v == 5'd28) begin
          r.mode = MODE_MIXED;
        end else begin
          r.saved = m[1:0];
          r.mode  = MODE_PSHIFT_NEW;
        end
      end
      MODE_MIXED: begin
        if (v < 5'd25) begin
          r.has = 1'b1;
          r.ch  = mixed_char(v);
        end else if (v == 5'd25) begin
          r.mode = MODE_PUNCT;
        end else if (v == 5'd26) begin
          r.has = 1'b1;
          r.ch  = 7'd32;
        end else if (v == 5'd27) begin
          r.mode = MODE_LOWER;
        end else if (v == 5'd28) begin
          r.mode = MODE_ALPHA;
        end else begin
          r.saved = m[1:0];
          r.mode  = MODE_PSHIFT_NEW;
        end
      end
      MODE_PUNCT: begin
        if (v < 5'd29) begin
          r.has = 1'b1;
          r.ch  = punct_char(v);
        end else begin
          r.mode = MODE_ALPHA;
        end
      end
      MODE_ASHIFT: begin
        r.mode = {1'b0, saved};
        if (v < 5'd26) begin
          r.has = 1'b1;
          r.ch  = 7'(7'd65 + 7'(v));
        end else if (v == 5'd26) begin
          r.has = 1'b1;
          r.ch  = 7'd32;
        end
      end
      default: begin
        // punctuation shift, one value then back to the saved mode; 29 latches alpha
        r.mode = {1'b0, saved};
        if (v < 5'd29) begin
          r.has = 1'b1;
          r.ch  = punct_char(v);
        end else begin
          r.mode = MODE_ALPHA;
        end
      end
    endcase
    return r;
  endfunction

  // base-30 split by reciprocal multiply, 1093 / 2^15 ~ 1/30
  logic [20:0] recip_prod;
  logic [4:0]  hi_val;
  logic [9:0]  hi_x30;
  logic [9:0]  lo_raw;
  logic [4:0]  lo_val;

  assign recip_prod = 21'(codeword) * 21'd1093;
  assign hi_val     = recip_prod[19:15];
  assign hi_x30     = 10'(hi_val) * 10'd30;
  assign lo_raw     = codeword - hi_x30;
  assign lo_val     = (lo_raw >= 10'd30) ? 5'(lo_raw - 10'd30) : lo_raw[4:0];

  text_res_t t1;
  text_res_t t2;

  assign t1 = text_step(st.sub_mode, st.saved_mode, hi_val);
  assign t2 = text_step(t1.mode, t1.saved, lo_val);

  logic    is_eci;
  logic    is_term;
  logic    ev0_v;
  logic    ev1_v;
  result_t ev0;
  result_t ev1;
  result_t ev2;

  always_comb begin
    is_eci  = (codeword >= 10'd925) && (codeword <= 10'd927);
    is_term = (codeword == 10'd901) || (codeword == 10'd902) || (codeword == 10'd922) ||
              (codeword == 10'd923) || (codeword == 10'd924) || (codeword == 10'd928);
    st_nxt     = st;
    ev0_v      = 1'b0;
    ev1_v      = 1'b0;
    ev0.kind   = KIND_CHAR;
    ev0.value  = '0;
    ev1.kind   = KIND_CHAR;
    ev1.value  = 10'(t2.ch);
    ev2.kind   = KIND_END;
    ev2.value  = '0;

    if (st.error_seen) begin
      // hold until the last codeword
    end else if (st.eci_args_left != 2'd0) begin
      st_nxt.eci_args_left = st.eci_args_left - 2'd1;
    end else if (st.byte_pending) begin
      if (is_eci) begin
        st_nxt.eci_args_left = (codeword == CW_ECI_GEN) ? 2'd2 : 2'd1;
      end else begin
        ev0_v               = 1'b1;
        ev0.kind            = KIND_BYTE;
        ev0.value           = codeword;
        st_nxt.byte_pending = 1'b0;
      end
    end else if (codeword < CW_TEXT_LATCH) begin
      ev0_v             = t1.has;
      ev0.value         = 10'(t1.ch);
      ev1_v             = t2.has;
      st_nxt.sub_mode   = t2.mode;
      st_nxt.saved_mode = t2.saved;
    end else if (codeword == CW_BYTE_SHIFT) begin
      // a fresh punctuation shift right before a byte shift is cancelled
      if (st.sub_mode == MODE_PSHIFT_NEW) begin
        st_nxt.sub_mode = {1'b0, st.saved_mode};
      end
      st_nxt.byte_pending = 1'b1;
    end else if (is_eci) begin
      if (st.sub_mode == MODE_PSHIFT_NEW) begin
        st_nxt.sub_mode = MODE_PSHIFT;
      end
      st_nxt.eci_args_left = (codeword == CW_ECI_GEN) ? 2'd2 : 2'd1;
    end else if (codeword == CW_TEXT_LATCH) begin
      st_nxt.sub_mode   = MODE_ALPHA;
      st_nxt.saved_mode = MODE_ALPHA[1:0];
    end else if (is_term) begin
      ev0_v             = 1'b1;
      ev0.kind          = KIND_TERM;
      ev0.value         = codeword;
      st_nxt.sub_mode   = MODE_ALPHA;
      st_nxt.saved_mode = MODE_ALPHA[1:0];
    end else begin
      ev0_v             = 1'b1;
      ev0.kind          = KIND_ERROR;
      st_nxt.error_seen = 1'b1;
    end

    if (last_codeword) begin
      st_nxt = '0;
    end

    // pack the events to the front of the bundle
    bundle.res[0] = ev0_v ? ev0 : (ev1_v ? ev1 : ev2);
    bundle.res[1] = (ev0_v && ev1_v) ? ev1 : ev2;
    bundle.res[2] = ev2;
    bundle.cnt    = 2'(ev0_v) + 2'(ev1_v) + 2'(last_codeword);
  end

endmodule

// ===== rtl/pdf417_text_compaction_decoder.sv =====
// ----------------------------------------------------------------------------
// pdf417_text_compaction_decoder
// text compaction decoder for pdf417 codeword streams
// ----------------------------------------------------------------------------
//  channel | dir | tdata               | tuser    | tlast
//  in_     | in  | [9:0] codeword      | -        | last_codeword
//  out_    | out | [9:0] value         | [2:0] kind | last_of_run
//
//  a codeword is decoded in the cycle it is taken and its results (zero to
//  three) sit in a result register; they leave one per cycle while the
//  output is ready, through the single output port; a codeword without
//  results leaves the decoder free for the next codeword
//  the next codeword is taken in the cycle the final result of the previous
//  one leaves, so output stalls hold off the input
//  synchronous active-low reset returns all decoder state to alpha mode
// ----------------------------------------------------------------------------
module pdf417_text_compaction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] codeword, [15:10] zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] value, [15:10] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);
  import ptcd_pkg::*;

  dec_state_t st_r;
  dec_state_t st_nxt;
  bundle_t    bundle_nxt;
  bundle_t    bundle_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       in_fire;
  logic       out_fire;
  logic       out_final;
  result_t    cur_res;

  ptcd_step u_step (
    .st            (st_r),
    .codeword      (in_tdata[CW_W-1:0]),
    .last_codeword (in_tlast),
    .st_nxt        (st_nxt),
    .bundle        (bundle_nxt)
  );

  assign cur_res    = bundle_r.res[idx_r];
  assign out_final  = (idx_r == bundle_r.cnt - 2'd1);
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = !busy_r || (out_fire && out_final);
  assign in_fire    = in_tvalid && in_tready;

  assign out_tvalid = busy_r;
  assign out_tdata  = {6'd0, cur_res.value};
  assign out_tuser  = cur_res.kind;
  assign out_tlast  = out_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire && bundle_nxt.cnt != 2'd0) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (out_fire) begin
        if (out_final) begin
          busy_r <= 1'b0;
          idx_r  <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && bundle_nxt.cnt != 2'd0) begin
      bundle_r <= bundle_nxt;
    end
  end

`ifndef SYNTHESIS
  // the read pointer stays inside the held run
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (bundle_r.cnt != 2'd0) && (idx_r < bundle_r.cnt))
    else $error("result pointer outside the held run");

  // a new request while busy only when the held run finishes now
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |-> (out_fire && out_final))
    else $error("request taken over an unfinished run");

  // end of data always closes its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_END) |-> out_tlast)
    else $error("end of data not last in run");

  // after an error nothing else is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.error_seen |-> (st_r.eci_args_left == 2'd0) && !st_r.byte_pending)
    else $error("error state with pending work");

  // a last codeword leaves the decoder in its reset state
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (st_r == '0))
    else $error("state not cleared after last codeword");
`endif

endmodule
